@@ rtl/core/fa2_pkg.sv @@
package fa2_pkg;

    // Defaults for the top-level parameters
    localparam int IN_WIDTH_DEF   = 16;
    localparam int ANGLE_FRAC_DEF = 13;

    // Ratio r is signed Q1.15; the divider yields one quotient bit per cell
    localparam int R_FRAC   = 15;
    localparam int QUO_BITS = R_FRAC + 1;
    localparam int RSQ_W    = 2 * QUO_BITS;

    // Cubic coefficients, unsigned Q1.15
    localparam int COEF_CUBE = 6432;
    localparam int COEF_LIN  = 32168;

    // Polynomial term width (always negative, magnitude below 2^45)
    localparam int T_W = 48;

    // Angle sum is exact in Q.60
    localparam int SUM_W    = 64;
    localparam int SUM_FRAC = 4 * R_FRAC;

    localparam logic signed [SUM_W-1:0] BASE_QUARTER       = 64'sh0C90FDAA22168C23;
    localparam logic signed [SUM_W-1:0] BASE_THREE_QUARTER = 64'sh25B2F8FE6643A46A;

    // Sign and branch bits that ride along with each transaction
    typedef struct packed {
        logic num_neg;   // ratio numerator negative
        logic hi_base;   // x negative: base is 3pi/4
        logic y_neg;     // final angle is negated
    } fa2_flags_t;

endpackage

@@ rtl/core/fa2_prep.sv @@
module fa2_prep #(
    parameter int IN_WIDTH = fa2_pkg::IN_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [IN_WIDTH-1:0]        y_value,
    input  logic [IN_WIDTH-1:0]        x_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IN_WIDTH+2:0]        out_rem,
    output logic [IN_WIDTH+1:0]        out_den,
    output fa2_pkg::fa2_flags_t        out_flags
);
    import fa2_pkg::*;

    localparam int DEN_W = IN_WIDTH + 2;
    localparam int REM_W = IN_WIDTH + 3;

    logic             load;
    logic             y_neg;
    logic             x_neg;
    logic [DEN_W-1:0] yy;
    logic [DEN_W-1:0] xx;
    logic [DEN_W-1:0] ay;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] num_mag;

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    fa2_flags_t       flags_reg;
    fa2_flags_t       flags_next;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb
    begin
        y_neg = y_value[IN_WIDTH-1];
        x_neg = x_value[IN_WIDTH-1];
        // one extra fractional bit on both operands
        yy = {y_neg, y_value, 1'b0};
        xx = {x_neg, x_value, 1'b0};
        // |2y| + 1 keeps the divisor nonzero
        ay = (y_neg ? (~yy + DEN_W'(1)) : yy) + DEN_W'(1);
        if (x_neg)
        begin
            num      = xx + ay;
            den_next = ay - xx;
        end
        else
        begin
            num      = xx - ay;
            den_next = xx + ay;
        end
        num_mag            = num[DEN_W-1] ? (~num + DEN_W'(1)) : num;
        rem_next           = {1'b0, num_mag};
        flags_next.num_neg = num[DEN_W-1];
        flags_next.hi_base = x_neg;
        flags_next.y_neg   = y_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;

endmodule

@@ rtl/core/fa2_div_cell.sv @@
module fa2_div_cell #(
    parameter int IN_WIDTH = fa2_pkg::IN_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [IN_WIDTH+2:0]             in_rem,
    input  logic [IN_WIDTH+1:0]             in_den,
    input  logic [fa2_pkg::QUO_BITS-1:0]    in_quo,
    input  fa2_pkg::fa2_flags_t             in_flags,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [IN_WIDTH+2:0]             out_rem,
    output logic [IN_WIDTH+1:0]             out_den,
    output logic [fa2_pkg::QUO_BITS-1:0]    out_quo,
    output fa2_pkg::fa2_flags_t             out_flags
);
    import fa2_pkg::*;

    localparam int DEN_W = IN_WIDTH + 2;
    localparam int REM_W = IN_WIDTH + 3;

    logic                load;
    logic                quo_bit;
    logic [REM_W-1:0]    diff;

    logic                valid_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [QUO_BITS-1:0] quo_next;
    fa2_flags_t          flags_reg;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // restoring step: remainder stays below den, so the shift never overflows
    always_comb
    begin
        quo_bit  = (in_rem >= REM_W'(in_den));
        diff     = in_rem - (quo_bit ? REM_W'(in_den) : '0);
        rem_next = {diff[REM_W-2:0], 1'b0};
        quo_next = {in_quo[QUO_BITS-2:0], quo_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= rem_next;
            den_reg   <= in_den;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

@@ rtl/core/fa2_poly.sv @@
module fa2_poly #(
    parameter int ANGLE_FRAC = fa2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fa2_pkg::QUO_BITS-1:0]    in_quo,
    input  fa2_pkg::fa2_flags_t             in_flags,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ANGLE_FRAC+2:0]           angle
);
    import fa2_pkg::*;

    localparam int NST     = 6;
    localparam int ANGLE_W = ANGLE_FRAC + 3;
    localparam int SH      = SUM_FRAC - ANGLE_FRAC;
    localparam int OVF_LSB = SH + ANGLE_W - 1;
    localparam logic [SUM_W-1:0] HALF     = SUM_W'(1) << (SH - 1);
    localparam logic [T_W-1:0]   LIN_TERM = T_W'(COEF_LIN) << (2 * R_FRAC);

    logic ld [NST];
    logic valid_reg [NST];

    // stage 1: signed ratio and its square
    logic [QUO_BITS-1:0]     r1_reg;
    logic [QUO_BITS-1:0]     r1_next;
    logic [RSQ_W-1:0]        rsq1_reg;
    logic [RSQ_W-1:0]        rsq1_next;
    fa2_flags_t              fl1_reg;
    // stage 2: C3*r^2 - C1
    logic signed [T_W-1:0]   t2_reg;
    logic signed [T_W-1:0]   t2_next;
    logic signed [QUO_BITS-1:0] r2_reg;
    fa2_flags_t              fl2_reg;
    // stage 3: times r
    logic signed [SUM_W-1:0] prod3_reg;
    logic signed [SUM_W-1:0] prod3_next;
    fa2_flags_t              fl3_reg;
    // stage 4: plus base
    logic signed [SUM_W-1:0] sum4_reg;
    logic signed [SUM_W-1:0] sum4_next;
    logic                    yneg4_reg;
    // stage 5: magnitude and result sign
    logic [SUM_W-1:0]        mag5_reg;
    logic [SUM_W-1:0]        mag5_next;
    logic                    neg5_reg;
    logic                    neg5_next;
    // stage 6: rounding, saturation, sign
    logic [SUM_W-1:0]        rnd;
    logic [ANGLE_W-2:0]      mag_out;
    logic [ANGLE_W-1:0]      angle_reg;
    logic [ANGLE_W-1:0]      angle_next;

    // each stage loads when empty or when the next one moves on
    always_comb
    begin
        ld[NST-1] = !valid_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            ld[k] = !valid_reg[k] || ld[k+1];
    end

    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            if (ld[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_comb
    begin
        r1_next    = in_flags.num_neg ? (~in_quo + QUO_BITS'(1)) : in_quo;
        // r^2 equals q^2 whatever the sign
        rsq1_next  = RSQ_W'(in_quo) * RSQ_W'(in_quo);
        t2_next    = $signed(T_W'(rsq1_reg) * T_W'(COEF_CUBE) - LIN_TERM);
        prod3_next = SUM_W'(t2_reg) * SUM_W'(r2_reg);
        sum4_next  = (fl3_reg.hi_base ? BASE_THREE_QUARTER : BASE_QUARTER) + prod3_reg;
        neg5_next  = sum4_reg[SUM_W-1] ^ yneg4_reg;
        mag5_next  = sum4_reg[SUM_W-1] ? (~sum4_reg + SUM_W'(1)) : sum4_reg;
        // round half away from zero on the magnitude, then clamp
        rnd        = mag5_reg + HALF;
        mag_out    = (|rnd[SUM_W-1:OVF_LSB]) ? '1 : rnd[OVF_LSB-1:SH];
        angle_next = neg5_reg ? (~{1'b0, mag_out} + ANGLE_W'(1)) : {1'b0, mag_out};
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            r1_reg   <= r1_next;
            rsq1_reg <= rsq1_next;
            fl1_reg  <= in_flags;
        end
        if (ld[1])
        begin
            t2_reg  <= t2_next;
            r2_reg  <= $signed(r1_reg);
            fl2_reg <= fl1_reg;
        end
        if (ld[2])
        begin
            prod3_reg <= prod3_next;
            fl3_reg   <= fl2_reg;
        end
        if (ld[3])
        begin
            sum4_reg  <= sum4_next;
            yneg4_reg <= fl3_reg.y_neg;
        end
        if (ld[4])
        begin
            mag5_reg <= mag5_next;
            neg5_reg <= neg5_next;
        end
        if (ld[5])
            angle_reg <= angle_next;
    end

    assign out_valid = valid_reg[NST-1];
    assign angle     = angle_reg;

endmodule

@@ rtl/core/fast_atan2_approx.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------
// input    | in_valid / in_stall  | y_value, x_value: signed IN_WIDTH bits
// output   | out_valid / out_stall| angle: signed Q3.ANGLE_FRAC radians
//
// One transaction per cycle sustained while out_stall is low; the pipeline has
// 1 operand stage, 16 divider cells and 6 polynomial and rounding stages.
// The ratio divider is a row of restoring cells, one quotient bit per cell.
// Reset clears only the valid bits; the data registers are not reset.
// out_stall freezes the output register; earlier stages keep filling bubbles,
// and in_stall rises only once every stage holds a transaction.
module fast_atan2_approx #(
    parameter int IN_WIDTH   = fa2_pkg::IN_WIDTH_DEF,
    parameter int ANGLE_FRAC = fa2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_WIDTH-1:0]   y_value,
    input  logic [IN_WIDTH-1:0]   x_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ANGLE_FRAC+2:0] angle
);
    import fa2_pkg::*;

    localparam int DEN_W   = IN_WIDTH + 2;
    localparam int REM_W   = IN_WIDTH + 3;
    localparam int ANGLE_W = ANGLE_FRAC + 3;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic [QUO_BITS-1:0] QUO_ONE  = QUO_BITS'(1) << R_FRAC;

    // link k feeds divider cell k; link QUO_BITS feeds the polynomial
    logic                valid_w [QUO_BITS+1];
    logic                ready_w [QUO_BITS+1];
    logic [REM_W-1:0]    rem_w   [QUO_BITS+1];
    logic [DEN_W-1:0]    den_w   [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_w   [QUO_BITS+1];
    fa2_flags_t          flags_w [QUO_BITS+1];
    logic                prep_ready;

    assign in_stall = !prep_ready;
    assign quo_w[0] = '0;

    fa2_prep #(
        .IN_WIDTH (IN_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (valid_w[0]),
        .out_ready (ready_w[0]),
        .out_rem   (rem_w[0]),
        .out_den   (den_w[0]),
        .out_flags (flags_w[0])
    );

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        fa2_div_cell #(
            .IN_WIDTH (IN_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_rem    (rem_w[i]),
            .in_den    (den_w[i]),
            .in_quo    (quo_w[i]),
            .in_flags  (flags_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_den   (den_w[i+1]),
            .out_quo   (quo_w[i+1]),
            .out_flags (flags_w[i+1])
        );
    end

    fa2_poly #(
        .ANGLE_FRAC (ANGLE_FRAC)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_w[QUO_BITS]),
        .in_ready  (ready_w[QUO_BITS]),
        .in_quo    (quo_w[QUO_BITS]),
        .in_flags  (flags_w[QUO_BITS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

    // quotient never exceeds one, and reaches it only for a negative ratio
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[QUO_BITS] |-> (quo_w[QUO_BITS] < QUO_ONE) ||
            (quo_w[QUO_BITS] == QUO_ONE && flags_w[QUO_BITS].num_neg))
        else $error("divider quotient out of range");

    // saturation keeps the angle symmetric
    a_angle_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle != ANGLE_MIN)
        else $error("angle hit the most negative code");

    // input backpressure only when the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output is free");

    // a held result stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("held result changed");

endmodule
